### sv/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared widths, codes and item types for the midpoint line rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int WALK_BITS  = COORD_BITS + 1;
  localparam int STEP_BITS  = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 3;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic [2:0] ZONE_0 = 3'd0;
  localparam logic [2:0] ZONE_1 = 3'd1;
  localparam logic [2:0] ZONE_2 = 3'd2;
  localparam logic [2:0] ZONE_3 = 3'd3;
  localparam logic [2:0] ZONE_4 = 3'd4;
  localparam logic [2:0] ZONE_5 = 3'd5;
  localparam logic [2:0] ZONE_6 = 3'd6;
  localparam logic [2:0] ZONE_7 = 3'd7;

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
  } in_item_t;

  typedef struct packed {
    logic                          valid_res;
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic [2:0]                    octant;
    logic                          last;
  } out_item_t;

  // Classified item passed from front end to walker
  typedef struct packed {
    logic                          kind;
    logic [2:0]                    zone;
    logic signed [WALK_BITS-1:0]   walk_x;
    logic signed [WALK_BITS-1:0]   walk_y;
    logic signed [WALK_BITS-1:0]   stop_x;
    logic signed [DEC_BITS-1:0]    decision;
    logic signed [STEP_BITS-1:0]   step_straight;
    logic signed [DEC_BITS-1:0]    step_diagonal;
  } cmd_t;

endpackage

`default_nettype wire

### sv/midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Eight-zone midpoint line rasteriser: a start item loads a line and emits
// its first pixel, each step item emits the next pixel (an idle result if no line is in progress).
// ----------------------------------------------------------------------------
//  channel | signals                      | carries
//  in      | in_valid, in_ready, in_item  | start or step item
//  out     | out_valid, out_ready, out_item | one pixel (or idle result)
//
//  One item per cycle sustained while the output does not stall; a result passes
//  through the classify register, the two-entry queue and the output register.
//  The walker's single add-and-compare per step sets the pixel rate.
//  Reset empties the classify register and the queue and clears out_valid and the busy flag.
//  Output stalls fill the queue, then drop in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer
  import mlr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic  push;
  logic  q_full;
  cmd_t  push_data;
  logic  pop;
  logic  head_valid;
  cmd_t  head;

  mlr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .push      (push),
    .q_full    (q_full),
    .push_data (push_data)
  );

  mlr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mlr_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

### sv/mlr_front.sv
// ----------------------------------------------------------------------------
// mlr_front
// Accepts items, classifies the zone and maps start items into the canonical
// octant, then pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_front
  import mlr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           push,
  input  wire logic      q_full,
  output cmd_t           push_data
);

  typedef struct packed {
    logic signed [WALK_BITS-1:0] u;
    logic signed [WALK_BITS-1:0] v;
  } uv_t;

  function automatic uv_t to_canon(logic [2:0] z, logic signed [COORD_BITS-1:0] x,
                                   logic signed [COORD_BITS-1:0] y);
    uv_t                         r;
    logic signed [WALK_BITS-1:0] xe;
    logic signed [WALK_BITS-1:0] ye;
    xe = WALK_BITS'(x);
    ye = WALK_BITS'(y);
    unique case (z)
      ZONE_0: begin r.u = -xe; r.v = -ye; end
      ZONE_1: begin r.u = -ye; r.v = -xe; end
      ZONE_2: begin r.u = -ye; r.v = xe;  end
      ZONE_3: begin r.u = xe;  r.v = -ye; end
      ZONE_4: begin r.u = xe;  r.v = ye;  end
      ZONE_5: begin r.u = ye;  r.v = xe;  end
      ZONE_6: begin r.u = ye;  r.v = -xe; end
      ZONE_7: begin r.u = -xe; r.v = ye;  end
    endcase
    return r;
  endfunction

  logic                         stage_valid;
  in_item_t                     stage_item;
  logic [2:0]                   stage_zone;

  logic signed [WALK_BITS-1:0]  dx;
  logic signed [WALK_BITS-1:0]  dy;
  logic [WALK_BITS-1:0]         ax;
  logic [WALK_BITS-1:0]         ay;
  logic                         flat;
  logic [2:0]                   zone;

  uv_t                          uv0;
  uv_t                          uv1;
  logic signed [WALK_BITS-1:0]  du;
  logic signed [WALK_BITS-1:0]  dv;
  logic signed [STEP_BITS-1:0]  neg2dv;

  assign in_ready = !stage_valid || !q_full;
  assign push     = stage_valid && !q_full;

  always_comb begin
    dx   = WALK_BITS'(in_item.end_x) - WALK_BITS'(in_item.start_x);
    dy   = WALK_BITS'(in_item.end_y) - WALK_BITS'(in_item.start_y);
    ax   = dx[WALK_BITS-1] ? -dx : dx;
    ay   = dy[WALK_BITS-1] ? -dy : dy;
    flat = ax >= ay;
    priority if (!dx[WALK_BITS-1] && !dy[WALK_BITS-1]) begin
      zone = flat ? ZONE_0 : ZONE_1;
    end else if (dx[WALK_BITS-1] && !dy[WALK_BITS-1]) begin
      zone = flat ? ZONE_3 : ZONE_2;
    end else if (dx[WALK_BITS-1]) begin
      zone = flat ? ZONE_4 : ZONE_5;
    end else begin
      zone = flat ? ZONE_7 : ZONE_6;
    end
  end

  always_comb begin
    uv0    = to_canon(stage_zone, stage_item.start_x, stage_item.start_y);
    uv1    = to_canon(stage_zone, stage_item.end_x, stage_item.end_y);
    du     = uv1.u - uv0.u;
    dv     = uv1.v - uv0.v;
    neg2dv = -(STEP_BITS'(dv) <<< 1);
    push_data.kind          = stage_item.kind;
    push_data.zone          = stage_zone;
    push_data.walk_x        = uv0.u;
    push_data.walk_y        = uv0.v;
    push_data.stop_x        = uv1.u;
    push_data.decision      = DEC_BITS'(neg2dv) + DEC_BITS'(du);
    push_data.step_straight = neg2dv;
    push_data.step_diagonal = DEC_BITS'(neg2dv) + (DEC_BITS'(du) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
      stage_zone <= zone;
    end
  end

endmodule

`default_nettype wire

### sv/mlr_queue.sv
// ----------------------------------------------------------------------------
// mlr_queue
// Two-entry queue of classified items between front end and walker.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_queue
  import mlr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire cmd_t  push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output cmd_t       head
);

  cmd_t        slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### sv/mlr_walk.sv
// ----------------------------------------------------------------------------
// mlr_walk
// Holds the line being drawn, takes one queued item per cycle unless the output stalls,
// and emits one pixel (or an idle result), mapped back to screen space, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_walk
  import mlr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  wire cmd_t  head,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_item
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } xy_t;

  function automatic xy_t to_screen(logic [2:0] z, logic signed [WALK_BITS-1:0] u,
                                    logic signed [WALK_BITS-1:0] v);
    xy_t                         r;
    logic signed [WALK_BITS-1:0] nu;
    logic signed [WALK_BITS-1:0] nv;
    nu = -u;
    nv = -v;
    unique case (z)
      ZONE_0: begin r.x = nu[COORD_BITS-1:0]; r.y = nv[COORD_BITS-1:0]; end
      ZONE_1: begin r.x = nv[COORD_BITS-1:0]; r.y = nu[COORD_BITS-1:0]; end
      ZONE_2: begin r.x = v[COORD_BITS-1:0];  r.y = nu[COORD_BITS-1:0]; end
      ZONE_3: begin r.x = u[COORD_BITS-1:0];  r.y = nv[COORD_BITS-1:0]; end
      ZONE_4: begin r.x = u[COORD_BITS-1:0];  r.y = v[COORD_BITS-1:0];  end
      ZONE_5: begin r.x = v[COORD_BITS-1:0];  r.y = u[COORD_BITS-1:0];  end
      ZONE_6: begin r.x = nv[COORD_BITS-1:0]; r.y = u[COORD_BITS-1:0];  end
      ZONE_7: begin r.x = nu[COORD_BITS-1:0]; r.y = v[COORD_BITS-1:0];  end
    endcase
    return r;
  endfunction

  logic                         busy;
  logic signed [WALK_BITS-1:0]  walk_x;
  logic signed [WALK_BITS-1:0]  walk_y;
  logic signed [WALK_BITS-1:0]  stop_x;
  logic signed [DEC_BITS-1:0]   decision;
  logic signed [STEP_BITS-1:0]  step_straight;
  logic signed [DEC_BITS-1:0]   step_diagonal;
  logic [2:0]                   held_zone;

  logic                         busy_next;
  logic signed [WALK_BITS-1:0]  walk_x_next;
  logic signed [WALK_BITS-1:0]  walk_y_next;
  logic signed [DEC_BITS-1:0]   decision_next;

  logic                         is_start;
  logic                         diag;
  logic signed [WALK_BITS-1:0]  sx;
  logic signed [WALK_BITS-1:0]  sy;
  logic signed [DEC_BITS-1:0]   sd;
  logic                         is_last;
  logic [2:0]                   z;
  xy_t                          pix;
  out_item_t                    res;

  assign pop      = head_valid && (!out_valid || out_ready);
  assign is_start = head.kind == KIND_START;

  always_comb begin
    diag = !decision[DEC_BITS-1];
    sx   = walk_x - WALK_BITS'(1);
    sy   = diag ? walk_y - WALK_BITS'(1) : walk_y;
    sd   = diag ? decision + step_diagonal : decision + DEC_BITS'(step_straight);

    if (is_start) begin
      z       = head.zone;
      pix     = to_screen(head.zone, head.walk_x, head.walk_y);
      is_last = head.walk_x == head.stop_x;
    end else begin
      z       = held_zone;
      pix     = to_screen(held_zone, sx, sy);
      is_last = sx <= stop_x;
    end

    if (is_start || busy) begin
      res.valid_res = 1'b1;
      res.pixel_x   = pix.x;
      res.pixel_y   = pix.y;
      res.octant    = z;
      res.last      = is_last;
    end else begin
      res = '0;
    end

    busy_next     = busy;
    walk_x_next   = walk_x;
    walk_y_next   = walk_y;
    decision_next = decision;
    if (is_start) begin
      busy_next     = !is_last;
      walk_x_next   = head.walk_x;
      walk_y_next   = head.walk_y;
      decision_next = head.decision;
    end else if (busy) begin
      busy_next     = !is_last;
      walk_x_next   = sx;
      walk_y_next   = sy;
      decision_next = sd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy      <= busy_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= res;
      walk_x   <= walk_x_next;
      walk_y   <= walk_y_next;
      decision <= decision_next;
      if (is_start) begin
        stop_x        <= head.stop_x;
        step_straight <= head.step_straight;
        step_diagonal <= head.step_diagonal;
        held_zone     <= head.zone;
      end
    end
  end

endmodule

`default_nettype wire

### sv/mlr_checker.sv
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks on the rasteriser's input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_checker
  import mlr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_item_t  in_item,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_item_t out_item
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_item)))
    else $error("input item withdrawn or changed while waiting");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.valid_res) |->
      (out_item.pixel_x == '0 && out_item.pixel_y == '0 &&
       out_item.octant == '0 && !out_item.last))
    else $error("idle result carries non-zero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_item))
    else $error("result changed while stalled");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (.*);

`default_nettype wire

### tb/midpoint_line_rasterizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_test
// Drives start and step items into the rasteriser with random gaps on both
// sides and checks every result against the table's expected pixel or an in-order
// line walker kept here: a short table of fixed lines first, then random short,
// long and abandoned lines mixed with stray items.
// ----------------------------------------------------------------------------

module midpoint_line_rasterizer_test;
  import mlr_pkg::*;

  localparam int ITEMS_TOTAL    = 550;
  localparam int MAX_GAP        = 18;
  localparam int CHOKE_AT       = 60;
  localparam int CHOKE_LEN      = 120;
  localparam int FLOOD_FIRST    = 50;
  localparam int FLOOD_LAST     = 160;
  localparam int DRAIN_AT       = 330;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic       kind;
    int         x0;
    int         y0;
    int         x1;
    int         y1;
    logic       typed;
    int         px;
    int         py;
    logic [2:0] zone;
    logic       last;
  } line_row_t;

  localparam int N_ROWS = 23;
  localparam line_row_t LINE_ROWS [0:N_ROWS-1] = '{
    '{KIND_STEP,      0,     0,     0,     0, 1'b1,     0,     0, ZONE_0, 1'b0},
    '{KIND_START,     5,     5,     5,     5, 1'b1,     5,     5, ZONE_0, 1'b1},
    '{KIND_STEP,      0,     0,     0,     0, 1'b1,     0,     0, ZONE_0, 1'b0},
    '{KIND_START,     0,     0,     7,     3, 1'b1,     0,     0, ZONE_0, 1'b0},
    '{KIND_START,    10,   -10,    12,    -2, 1'b1,    10,   -10, ZONE_1, 1'b0},
    '{KIND_START,   100,    20,    97,    30, 1'b1,   100,    20, ZONE_2, 1'b0},
    '{KIND_START,    -4,     6,   -13,     9, 1'b1,    -4,     6, ZONE_3, 1'b0},
    '{KIND_START,    30,    30,    22,    24, 1'b1,    30,    30, ZONE_4, 1'b0},
    '{KIND_START,   -50,   -60,   -53,   -70, 1'b1,   -50,   -60, ZONE_5, 1'b0},
    '{KIND_START,     7,     8,     9,     1, 1'b1,     7,     8, ZONE_6, 1'b0},
    '{KIND_START,     0,     0,     9,    -4, 1'b1,     0,     0, ZONE_7, 1'b0},
    '{KIND_STEP,      0,     0,     0,     0, 1'b0,     0,     0, ZONE_0, 1'b0},
    '{KIND_STEP,      0,     0,     0,     0, 1'b0,     0,     0, ZONE_0, 1'b0},
    '{KIND_START, -2048, -2048,  2047,  2047, 1'b1, -2048, -2048, ZONE_0, 1'b0},
    '{KIND_STEP,      0,     0,     0,     0, 1'b0,     0,     0, ZONE_0, 1'b0},
    '{KIND_START,  2047,  2047, -2048, -2048, 1'b1,  2047,  2047, ZONE_4, 1'b0},
    '{KIND_START, -2048,  2047,  2047, -2048, 1'b1, -2048,  2047, ZONE_7, 1'b0},
    '{KIND_START,  2047, -2048, -2048,  2047, 1'b1,  2047, -2048, ZONE_3, 1'b0},
    '{KIND_STEP,      0,     0,     0,     0, 1'b0,     0,     0, ZONE_0, 1'b0},
    '{KIND_START,     0,     0,     2,     1, 1'b1,     0,     0, ZONE_0, 1'b0},
    '{KIND_STEP,      0,     0,     0,     0, 1'b0,     0,     0, ZONE_0, 1'b0},
    '{KIND_STEP,      0,     0,     0,     0, 1'b0,     0,     0, ZONE_0, 1'b0},
    '{KIND_STEP,      0,     0,     0,     0, 1'b1,     0,     0, ZONE_0, 1'b0}
  };

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // line walker state, canonical octant
  logic       line_busy   = 1'b0;
  int         line_u      = 0;
  int         line_v      = 0;
  int         line_stop_u = 0;
  int         line_err    = 0;
  int         line_inc_w  = 0;
  int         line_inc_sw = 0;
  logic [2:0] line_zone   = ZONE_0;

  out_item_t pending_pixels [$];
  int        tx_count      = 0;
  int        rx_count      = 0;
  int        fail_count    = 0;
  int        lines_started = 0;
  int        idle_results  = 0;
  int        quiet_cycles  = 0;
  logic [7:0] zones_seen   = '0;

  midpoint_line_rasterizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void to_uv(input logic [2:0] z, input int x, input int y,
                                output int u, output int v);
    case (z)
      ZONE_0: begin u = -x; v = -y; end
      ZONE_1: begin u = -y; v = -x; end
      ZONE_2: begin u = -y; v = x;  end
      ZONE_3: begin u = x;  v = -y; end
      ZONE_4: begin u = x;  v = y;  end
      ZONE_5: begin u = y;  v = x;  end
      ZONE_6: begin u = y;  v = -x; end
      ZONE_7: begin u = -x; v = y;  end
    endcase
  endfunction

  function automatic out_item_t next_pixel(input in_item_t it);
    out_item_t  px;
    int         x0, y0, x1, y1, dx, dy, ax, ay;
    int         u0, v0, u1, v1, du, dv, u, v, sx, sy;
    logic       flat, fin;
    logic [2:0] z;
    px = '0;
    if (it.kind == KIND_STEP && !line_busy)
      return px;
    if (it.kind == KIND_START) begin
      x0 = int'(it.start_x);
      y0 = int'(it.start_y);
      x1 = int'(it.end_x);
      y1 = int'(it.end_y);
      dx = x1 - x0;
      dy = y1 - y0;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      flat = (ax >= ay);
      if (dx >= 0 && dy >= 0)
        z = flat ? ZONE_0 : ZONE_1;
      else if (dx < 0 && dy >= 0)
        z = flat ? ZONE_3 : ZONE_2;
      else if (dx < 0)
        z = flat ? ZONE_4 : ZONE_5;
      else
        z = flat ? ZONE_7 : ZONE_6;
      to_uv(z, x0, y0, u0, v0);
      to_uv(z, x1, y1, u1, v1);
      du = u1 - u0;
      dv = v1 - v0;
      line_zone   = z;
      line_u      = u0;
      line_v      = v0;
      line_stop_u = u1;
      line_err    = du - 2 * dv;
      line_inc_w  = -2 * dv;
      line_inc_sw = 2 * du - 2 * dv;
      fin = (u0 == u1);
      line_busy = !fin;
    end else begin
      line_u = line_u - 1;
      if (line_err < 0) begin
        line_err = line_err + line_inc_w;
      end else begin
        line_err = line_err + line_inc_sw;
        line_v   = line_v - 1;
      end
      fin = (line_u <= line_stop_u);
      if (fin)
        line_busy = 1'b0;
    end
    u = line_u;
    v = line_v;
    case (line_zone)
      ZONE_0: begin sx = -u; sy = -v; end
      ZONE_1: begin sx = -v; sy = -u; end
      ZONE_2: begin sx = v;  sy = -u; end
      ZONE_3: begin sx = u;  sy = -v; end
      ZONE_4: begin sx = u;  sy = v;  end
      ZONE_5: begin sx = v;  sy = u;  end
      ZONE_6: begin sx = -v; sy = u;  end
      ZONE_7: begin sx = -u; sy = v;  end
    endcase
    px.valid_res = 1'b1;
    px.pixel_x   = sx[COORD_BITS-1:0];
    px.pixel_y   = sy[COORD_BITS-1:0];
    px.octant    = line_zone;
    px.last      = fin;
    return px;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t    it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it  = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic void flag_error(input string what, input out_item_t want,
                                     input out_item_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: %s at result %0d: want v=%0b x=%0d y=%0d zone=%0d last=%0b",
               $time, what, rx_count, want.valid_res, want.pixel_x, want.pixel_y,
               want.octant, want.last);
    if (fail_count <= REPORT_MAX)
      $display("    got v=%0b x=%0d y=%0d zone=%0d last=%0b",
               got.valid_res, got.pixel_x, got.pixel_y, got.octant, got.last);
  endfunction

  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    int        gap;
    out_item_t pred;
    if (tx_count == DRAIN_AT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_pixels.size() != 0) @(posedge clk);
    end
    gap = $urandom_range(0, MAX_GAP);
    if ((tx_count >= FLOOD_FIRST && tx_count < FLOOD_LAST) || tx_count % 100 >= 85)
      gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = next_pixel(it);
    pending_pixels.push_back(typed ? want : pred);
    tx_count++;
    if (it.kind == KIND_START)
      lines_started++;
  endtask

  task automatic send_step();
    in_item_t it;
    it = noise_item();
    it.kind = KIND_STEP;
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_line(input int x0, input int y0, input int x1, input int y1,
                           input int max_steps);
    in_item_t it;
    int       n;
    it = noise_item();
    it.kind    = KIND_START;
    it.start_x = x0[COORD_BITS-1:0];
    it.start_y = y0[COORD_BITS-1:0];
    it.end_x   = x1[COORD_BITS-1:0];
    it.end_y   = y1[COORD_BITS-1:0];
    send_item(it, 1'b0, '0);
    n = 0;
    while (line_busy && n < max_steps) begin
      send_step();
      n++;
    end
  endtask

  task automatic check_pixel(input out_item_t got);
    out_item_t want;
    if (got.valid_res)
      zones_seen[got.octant] = 1'b1;
    else
      idle_results++;
    if (pending_pixels.size() == 0) begin
      flag_error("unexpected pixel", '0, got);
    end else begin
      want = pending_pixels.pop_front();
      if (got.valid_res !== want.valid_res || got.pixel_x !== want.pixel_x ||
          got.pixel_y !== want.pixel_y || got.octant !== want.octant ||
          got.last !== want.last)
        flag_error("pixel mismatch", want, got);
    end
    rx_count++;
  endtask

  task automatic collect_pixels();
    int gap;
    forever begin
      gap = $urandom_range(0, MAX_GAP);
      if (rx_count % 100 >= 20 && rx_count % 100 < 35)
        gap = 0;
      // long output stall so the queue fills and in_ready drops
      if (rx_count == CHOKE_AT)
        gap = CHOKE_LEN;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_pixel(out_item);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    out_item_t want;
    int x0, y0, x1, y1, pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    fork
      collect_pixels();
    join_none

    for (int i = 0; i < N_ROWS; i++) begin
      it = '0;
      it.kind    = LINE_ROWS[i].kind;
      it.start_x = LINE_ROWS[i].x0[COORD_BITS-1:0];
      it.start_y = LINE_ROWS[i].y0[COORD_BITS-1:0];
      it.end_x   = LINE_ROWS[i].x1[COORD_BITS-1:0];
      it.end_y   = LINE_ROWS[i].y1[COORD_BITS-1:0];
      want = '0;
      if (LINE_ROWS[i].kind == KIND_START) begin
        want.valid_res = 1'b1;
        want.pixel_x   = LINE_ROWS[i].px[COORD_BITS-1:0];
        want.pixel_y   = LINE_ROWS[i].py[COORD_BITS-1:0];
        want.octant    = LINE_ROWS[i].zone;
        want.last      = LINE_ROWS[i].last;
      end
      send_item(it, LINE_ROWS[i].typed, want);
    end

    while (tx_count < ITEMS_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        x0 = int'($urandom_range(0, 4055)) - 2028;
        y0 = int'($urandom_range(0, 4055)) - 2028;
        x1 = x0 + int'($urandom_range(0, 48)) - 24;
        y1 = y0 + int'($urandom_range(0, 48)) - 24;
        // mostly walked to the end, sometimes cut short by the next start
        send_line(x0, y0, x1, y1, (pick < 65) ? 64 : int'($urandom_range(0, 6)));
        if ($urandom_range(0, 3) == 0)
          send_step();
      end else if (pick < 85) begin
        x0 = int'($urandom_range(0, 4095)) - 2048;
        y0 = int'($urandom_range(0, 4095)) - 2048;
        x1 = int'($urandom_range(0, 4095)) - 2048;
        y1 = int'($urandom_range(0, 4095)) - 2048;
        send_line(x0, y0, x1, y1, int'($urandom_range(0, 40)));
      end else begin
        send_item(noise_item(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items over %0d lines, checked %0d results (%0d idle steps).",
             tx_count, lines_started, rx_count, idle_results);
    $display("Zones drawn %b, with one long output stall and one full drain; %0d errors.",
             zones_seen, fail_count);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### midpoint_line_rasterizer.f
sv/mlr_pkg.sv
sv/mlr_front.sv
sv/mlr_queue.sv
sv/mlr_walk.sv
sv/midpoint_line_rasterizer.sv
sv/mlr_checker.sv
tb/midpoint_line_rasterizer_test.sv
